// ----- rtl/gcam_pkg.sv -----
// ----------------------------------------------------------------------------
// gcam_pkg
// Shared types and constants for the 2D grid cell area / face normal block.
// ----------------------------------------------------------------------------
package gcam_pkg;

    localparam int COORD_BITS = 24;               // Q12.12 node coordinate
    localparam int DIFF_W     = COORD_BITS + 1;   // coordinate difference
    localparam int PROD_W     = 2 * DIFF_W;       // signed product
    localparam int SUM_W      = 2 * COORD_BITS + 2; // sum of two squares
    localparam int AREA_W     = 49;               // Q25.24 area
    localparam int NORM_W     = 16;               // Q1.15 component
    localparam int NPR_W      = 11;
    localparam int ROWS_W     = 16;
    localparam int CFG_W      = 16;
    localparam int QUO_W      = 32;               // quotient, one spare top bit
    localparam int DIV_STEPS  = 31;
    localparam int SQRT_STEPS = QUO_W / 2;
    localparam int STEP_W     = 5;

    // register indexes
    localparam logic CFG_NODES_PER_ROW = 1'b0;
    localparam logic CFG_ROWS_IN_GRID  = 1'b1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
    } t_in_item;

    typedef struct packed {
        logic [AREA_W-1:0]        cell_area;
        logic                     area_valid;
        logic signed [NORM_W-1:0] inormal_x;
        logic signed [NORM_W-1:0] inormal_y;
        logic                     inormal_valid;
        logic signed [NORM_W-1:0] jnormal_x;
        logic signed [NORM_W-1:0] jnormal_y;
        logic                     jnormal_valid;
        logic                     grid_done;
    } t_out_item;

endpackage

// ----- rtl/grid_cell_area_and_face_normals_2d.sv -----
// ----------------------------------------------------------------------------
// grid_cell_area_and_face_normals_2d
// Streaming quad area and unit i/j edge normals over a raster-order 2D grid.
// Accepts one node at a time: the input stalls until the result of the last
// node has been loaded into the output register. Each node passes the input
// transfer, line store read, multiply slots, the 31-step serial divide and
// 16-step serial root in the normal units, and the output hand-off.
// Reset (sync, active low): counters and left/up-left nodes to zero, registers
// to nodes_per_row=1024, rows_in_grid=2; the line store is not cleared.
// ----------------------------------------------------------------------------
module grid_cell_area_and_face_normals_2d #(
    parameter int MAX_ROW_NODES = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input node channel
    input  logic                      i_in_valid,
    input  gcam_pkg::t_in_item        i_in_data,
    output logic                      o_in_stall,
    // result channel
    output logic                      o_out_valid,
    output gcam_pkg::t_out_item       o_out_data,
    input  logic                      i_out_stall,
    // configuration write channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_index,
    input  logic [gcam_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int CNT_W   = (MAX_ROW_NODES > 2) ? $clog2(MAX_ROW_NODES) : 1;
    localparam int CMP_W   = ((CNT_W > gcam_pkg::NPR_W) ? CNT_W : gcam_pkg::NPR_W) + 1;
    localparam int CB      = gcam_pkg::COORD_BITS;
    localparam int DW      = gcam_pkg::DIFF_W;
    localparam int PW      = gcam_pkg::PROD_W;
    localparam int SW      = gcam_pkg::SUM_W;
    localparam int MUL_N   = 6;                 // products per node

    typedef enum logic [2:0] {S_IDLE, S_READ, S_MUL, S_NORM, S_OUT} t_state;

    t_state                       r_state;
    logic [gcam_pkg::NPR_W-1:0]   r_npr;
    logic [gcam_pkg::ROWS_W-1:0]  r_rows;
    logic [CNT_W-1:0]             r_col;
    logic [gcam_pkg::ROWS_W-1:0]  r_row;

    // node registers: {x, y}
    gcam_pkg::t_in_item           r_cur, r_left, r_up, r_diag, r_upleft;
    gcam_pkg::t_in_item           r_prev;        // left node seen by this item
    logic                         r_has_i, r_has_j, r_last;
    logic [2:0]                   r_k;
    logic signed [PW-1:0]         r_prod;
    logic signed [PW-1:0]         r_pa;
    logic signed [PW:0]           r_adiff;
    logic [PW-1:0]                r_ix2, r_iy2, r_jx2, r_jy2;
    logic                         r_out_valid;
    gcam_pkg::t_out_item          r_out;

    logic [2*CB-1:0]              w_rdata;
    logic                         w_accept;
    logic                         w_take;
    logic                         w_start;
    logic [3:0]                   w_done;
    logic signed [gcam_pkg::NORM_W-1:0] w_comp [4];

    // edge and diagonal differences
    logic signed [DW-1:0] d_ax, d_ay, d_bx, d_by;
    logic signed [DW-1:0] d_idx, d_idy, d_jdx, d_jdy;
    logic signed [DW-1:0] m_a, m_b;
    logic [SW-1:0]        s_i, s_j;

    // clamped geometry
    logic [CMP_W-1:0]              n_npr;
    logic [gcam_pkg::ROWS_W-1:0]   n_rows;
    logic                          n_last_col, n_last_row;
    logic signed [PW:0]            n_abs;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_take      = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;
    // start once the last square has landed in r_jy2
    assign w_start     = (r_state == S_MUL) && (r_k == 3'(MUL_N + 1));

    gcam_line_store #(
        .DEPTH (MAX_ROW_NODES),
        .AW    (CNT_W),
        .DW    (2 * CB)
    ) u_line (
        .i_clk   (i_clk),
        .i_en    (w_accept),
        .i_addr  (r_col),
        .i_wdata (i_in_data),
        .o_rdata (w_rdata)
    );

    always_comb begin
        // area = |(diag-cur) x-part * (up-left) y-part - ...| / 2
        d_ax  = DW'(r_diag.coord_x) - DW'(r_cur.coord_x);
        d_ay  = DW'(r_up.coord_y)   - DW'(r_prev.coord_y);
        d_bx  = DW'(r_up.coord_x)   - DW'(r_prev.coord_x);
        d_by  = DW'(r_diag.coord_y) - DW'(r_cur.coord_y);
        d_idx = DW'(r_cur.coord_x)  - DW'(r_prev.coord_x);
        d_idy = DW'(r_cur.coord_y)  - DW'(r_prev.coord_y);
        d_jdx = DW'(r_cur.coord_x)  - DW'(r_up.coord_x);
        d_jdy = DW'(r_cur.coord_y)  - DW'(r_up.coord_y);
        case (r_k)
            3'd0:    begin m_a = d_ax;  m_b = d_ay;  end
            3'd1:    begin m_a = d_bx;  m_b = d_by;  end
            3'd2:    begin m_a = d_idx; m_b = d_idx; end
            3'd3:    begin m_a = d_idy; m_b = d_idy; end
            3'd4:    begin m_a = d_jdx; m_b = d_jdx; end
            3'd5:    begin m_a = d_jdy; m_b = d_jdy; end
            default: begin m_a = '0;    m_b = '0;    end
        endcase
        s_i = SW'(r_ix2) + SW'(r_iy2);
        s_j = SW'(r_jx2) + SW'(r_jy2);

        // clamp nodes_per_row to [2, MAX_ROW_NODES], rows_in_grid to >= 2
        if (r_npr < gcam_pkg::NPR_W'(2)) begin
            n_npr = CMP_W'(2);
        end else if (CMP_W'(r_npr) > CMP_W'(MAX_ROW_NODES)) begin
            n_npr = CMP_W'(MAX_ROW_NODES);
        end else begin
            n_npr = CMP_W'(r_npr);
        end
        n_rows     = (r_rows < gcam_pkg::ROWS_W'(2)) ? gcam_pkg::ROWS_W'(2) : r_rows;
        n_last_col = CMP_W'(r_col) >= (n_npr - 1'b1);
        n_last_row = r_row >= (n_rows - 1'b1);
        n_abs      = r_adiff[PW] ? -r_adiff : r_adiff;
    end

    // Normal units. i-edge normal is (dy, -dx), j-edge normal is (-dy, dx).
    gcam_norm u_nix (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (w_start),
        .i_mag2 (SW'(r_iy2)), .i_sum (s_i), .i_neg (d_idy[DW-1]),
        .o_done (w_done[0]), .o_comp (w_comp[0])
    );
    gcam_norm u_niy (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (w_start),
        .i_mag2 (SW'(r_ix2)), .i_sum (s_i),
        .i_neg (!d_idx[DW-1] && (d_idx != '0)),
        .o_done (w_done[1]), .o_comp (w_comp[1])
    );
    gcam_norm u_njx (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (w_start),
        .i_mag2 (SW'(r_jy2)), .i_sum (s_j),
        .i_neg (!d_jdy[DW-1] && (d_jdy != '0)),
        .o_done (w_done[2]), .o_comp (w_comp[2])
    );
    gcam_norm u_njy (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (w_start),
        .i_mag2 (SW'(r_jx2)), .i_sum (s_j), .i_neg (d_jdx[DW-1]),
        .o_done (w_done[3]), .o_comp (w_comp[3])
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_npr       <= gcam_pkg::NPR_W'(1024);
            r_rows      <= gcam_pkg::ROWS_W'(2);
            r_col       <= '0;
            r_row       <= '0;
            r_left      <= '0;
            r_upleft    <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    gcam_pkg::CFG_NODES_PER_ROW: r_npr  <= i_cfg_data[gcam_pkg::NPR_W-1:0];
                    gcam_pkg::CFG_ROWS_IN_GRID:  r_rows <= i_cfg_data;
                    default: ;
                endcase
            end
            // S_OUT owns the valid flag while it hands a result over
            if (w_take && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cur   <= i_in_data;
                        r_prev  <= r_left;
                        r_left  <= i_in_data;
                        r_has_i <= (r_col != '0);
                        r_has_j <= (r_row != '0);
                        r_last  <= n_last_col && n_last_row;
                        if (n_last_col) begin
                            r_col <= '0;
                            r_row <= n_last_row ? '0 : r_row + 1'b1;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    // line store data for this column has arrived
                    r_up     <= w_rdata;
                    r_diag   <= r_upleft;
                    r_upleft <= w_rdata;
                    r_k      <= '0;
                    r_state  <= S_MUL;
                end
                S_MUL: begin
                    // one product per cycle; the previous one is filed away
                    r_prod <= m_a * m_b;
                    case (r_k)
                        3'd1:    r_pa    <= r_prod;
                        3'd2:    r_adiff <= {r_pa[PW-1], r_pa} - {r_prod[PW-1], r_prod};
                        3'd3:    r_ix2   <= r_prod;
                        3'd4:    r_iy2   <= r_prod;
                        3'd5:    r_jx2   <= r_prod;
                        3'd6:    r_jy2   <= r_prod;
                        default: ;
                    endcase
                    if (r_k == 3'(MUL_N + 1)) begin
                        r_state <= S_NORM;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_NORM: begin
                    // normal units hold their components until the next start
                    if (w_done[0]) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // load the result once the output register is free
                    if (!r_out_valid || w_take) begin
                        r_out.cell_area     <= r_has_i && r_has_j
                                               ? n_abs[gcam_pkg::AREA_W:1] : '0;
                        r_out.area_valid    <= r_has_i && r_has_j;
                        r_out.inormal_x     <= r_has_i ? w_comp[0] : '0;
                        r_out.inormal_y     <= r_has_i ? w_comp[1] : '0;
                        r_out.inormal_valid <= r_has_i;
                        r_out.jnormal_x     <= r_has_j ? w_comp[2] : '0;
                        r_out.jnormal_y     <= r_has_j ? w_comp[3] : '0;
                        r_out.jnormal_valid <= r_has_j;
                        r_out.grid_done     <= r_last;
                        r_out_valid         <= 1'b1;
                        r_state             <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/gcam_line_store.sv -----
// ----------------------------------------------------------------------------
// gcam_line_store
// One-port line store for the previous row; read-before-write, registered read.
// ----------------------------------------------------------------------------
module gcam_line_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 48
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [AW-1:0] i_addr,
    input  logic [DW-1:0] i_wdata,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata        <= r_mem[i_addr];
            r_mem[i_addr]  <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/gcam_norm.sv -----
// ----------------------------------------------------------------------------
// gcam_norm
// One normal component: q = isqrt(floor(c^2 * 2^30 / s)), bit-serial divide
// (one quotient bit per cycle) then digit-serial root (one bit per cycle).
// ----------------------------------------------------------------------------
module gcam_norm (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [gcam_pkg::SUM_W-1:0]         i_mag2,
    input  logic [gcam_pkg::SUM_W-1:0]         i_sum,
    input  logic                               i_neg,
    output logic                               o_done,
    output logic signed [gcam_pkg::NORM_W-1:0] o_comp
);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_SQRT} t_state;

    t_state                             r_state;
    logic [gcam_pkg::STEP_W-1:0]        r_cnt;
    logic [gcam_pkg::SUM_W-1:0]         r_rem;
    logic [gcam_pkg::SUM_W-1:0]         r_div;
    logic                               r_bit0;
    logic                               r_neg;
    logic                               r_zero;
    logic [gcam_pkg::QUO_W-1:0]         r_quo;
    logic [gcam_pkg::NORM_W-1:0]        r_root;
    logic [gcam_pkg::NORM_W+2:0]        r_srem;
    logic                               r_done;
    logic signed [gcam_pkg::NORM_W-1:0] r_comp;

    logic [gcam_pkg::SUM_W:0]    n_shift;
    logic                        n_dge;
    logic [gcam_pkg::SUM_W:0]    n_dsub;
    logic [gcam_pkg::NORM_W+2:0] n_ssh;
    logic [gcam_pkg::NORM_W+2:0] n_trial;
    logic                        n_sge;
    logic [gcam_pkg::NORM_W+2:0] n_ssub;
    logic [gcam_pkg::NORM_W-1:0] n_root;
    logic [gcam_pkg::NORM_W-1:0] n_comp;

    always_comb begin
        // only the first shifted-in dividend bit can be nonzero
        n_shift = {r_rem, (r_cnt == '0) ? r_bit0 : 1'b0};
        n_dge   = n_shift >= {1'b0, r_div};
        n_dsub  = n_shift - {1'b0, r_div};
        n_ssh   = {r_srem[gcam_pkg::NORM_W:0], r_quo[gcam_pkg::QUO_W-1 -: 2]};
        n_trial = {1'b0, r_root, 2'b01};
        n_sge   = n_ssh >= n_trial;
        n_ssub  = n_ssh - n_trial;
        n_root  = {r_root[gcam_pkg::NORM_W-2:0], n_sge};
        if (r_zero) begin
            n_comp = '0;
        end else if (r_neg) begin
            n_comp = -n_root;
        end else if (n_root[gcam_pkg::NORM_W-1]) begin
            n_comp = {1'b0, {(gcam_pkg::NORM_W-1){1'b1}}};   // saturate at +1
        end else begin
            n_comp = n_root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_rem   <= i_mag2 >> 1;
                        r_bit0  <= i_mag2[0];
                        r_div   <= i_sum;
                        r_neg   <= i_neg;
                        r_zero  <= (i_sum == '0);
                        r_quo   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= n_dge ? n_dsub[gcam_pkg::SUM_W-1:0]
                                   : n_shift[gcam_pkg::SUM_W-1:0];
                    r_quo <= {r_quo[gcam_pkg::QUO_W-2:0], n_dge};
                    if (r_cnt == gcam_pkg::STEP_W'(gcam_pkg::DIV_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_root  <= '0;
                        r_srem  <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_SQRT: begin
                    r_srem <= n_sge ? n_ssub : n_ssh;
                    r_root <= n_root;
                    r_quo  <= r_quo << 2;
                    if (r_cnt == gcam_pkg::STEP_W'(gcam_pkg::SQRT_STEPS - 1)) begin
                        r_comp  <= n_comp;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_comp = r_comp;

endmodule

// ----- dv/grid_cell_area_and_face_normals_2d_tb.sv -----
// ----------------------------------------------------------------------------
// grid_cell_area_and_face_normals_2d_tb
// Self-checking bench: streams grid nodes through the block, predicts the cell
// area and unit edge normals per node, and compares each result transfer.
// ----------------------------------------------------------------------------
module grid_cell_area_and_face_normals_2d_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Tracks the grid walk and holds the metrics still owed by the block.
    class metric_board;
        localparam int MAX_NODES = 1024;

        gcam_pkg::t_out_item          owed_q[$];
        logic signed [gcam_pkg::COORD_BITS-1:0] line_x[MAX_NODES];
        logic signed [gcam_pkg::COORD_BITS-1:0] line_y[MAX_NODES];
        logic signed [gcam_pkg::COORD_BITS-1:0] left_x, left_y, diag_x, diag_y;
        int unsigned col, row, npr_reg, rows_reg;
        int errors;

        function void clear();
            owed_q.delete();
            left_x = '0; left_y = '0; diag_x = '0; diag_y = '0;
            col = 0; row = 0; npr_reg = 1024; rows_reg = 2; errors = 0;
        endfunction

        function void set_reg(logic idx, int unsigned val);
            if (idx == gcam_pkg::CFG_NODES_PER_ROW) npr_reg = val & 11'h7ff;
            else rows_reg = val & 16'hffff;
        endfunction

        // floor(|c|*32768/len) by bit-serial search; -1 maps to -32768, +1 saturates
        function logic signed [gcam_pkg::NORM_W-1:0] unit_comp(longint c, longint s);
            longint unsigned m;
            logic [127:0] lhs, rhs;
            logic [16:0] q, t;
            if (s == 0) return '0;
            m = (c < 0) ? -c : c;
            rhs = {64'd0, m * m} << 30;
            q = '0;
            for (int b = 15; b >= 0; b--) begin
                t = q | (17'd1 << b);
                lhs = 128'(t) * 128'(t) * 128'(s);
                if (lhs <= rhs) q = t;
            end
            if (c < 0) return gcam_pkg::NORM_W'(-$signed({1'b0, q[15:0]}));
            if (q > 17'd32767) q = 17'd32767;
            return q[15:0];
        endfunction

        function void note_node(gcam_pkg::t_in_item n);
            gcam_pkg::t_out_item r;
            longint cx, cy, ux, uy, lx, ly, dgx, dgy, a, b, nx, ny, s;
            int unsigned npr, rws;
            npr = (npr_reg < 2) ? 2 : (npr_reg > MAX_NODES ? MAX_NODES : npr_reg);
            rws = (rows_reg < 2) ? 2 : rows_reg;
            cx = n.coord_x; cy = n.coord_y;
            ux = (col < MAX_NODES) ? line_x[col] : 0;
            uy = (col < MAX_NODES) ? line_y[col] : 0;
            lx = left_x; ly = left_y; dgx = diag_x; dgy = diag_y;
            r = '0;
            if (col >= 1 && row >= 1) begin
                a = (dgx - cx) * (uy - ly);
                b = (ux - lx) * (dgy - cy);
                r.cell_area = gcam_pkg::AREA_W'(((a >= b) ? a - b : b - a) >> 1);
                r.area_valid = 1'b1;
            end
            if (col >= 1) begin
                nx = cy - ly; ny = -(cx - lx);
                s = nx * nx + ny * ny;
                r.inormal_x = unit_comp(nx, s);
                r.inormal_y = unit_comp(ny, s);
                r.inormal_valid = 1'b1;
            end
            if (row >= 1) begin
                nx = -(cy - uy); ny = cx - ux;
                s = nx * nx + ny * ny;
                r.jnormal_x = unit_comp(nx, s);
                r.jnormal_y = unit_comp(ny, s);
                r.jnormal_valid = 1'b1;
            end
            diag_x = ux; diag_y = uy;
            if (col < MAX_NODES) begin
                line_x[col] = n.coord_x; line_y[col] = n.coord_y;
            end
            left_x = n.coord_x; left_y = n.coord_y;
            r.grid_done = (col >= npr - 1) && (row >= rws - 1);
            if (col >= npr - 1) begin
                col = 0;
                row = (row >= rws - 1) ? 0 : ((row + 1) & 16'hffff);
            end else begin
                col++;
            end
            owed_q.insert(owed_q.size(), r);
        endfunction

        function void check_result(gcam_pkg::t_out_item got);
            gcam_pkg::t_out_item e;
            if (owed_q.size() == 0) begin
                $error("result transfer with nothing owed: %h", got);
                errors++;
                return;
            end
            e = owed_q.pop_front();
            if (got.cell_area !== e.cell_area) begin
                $error("cell_area exp %0d got %0d", e.cell_area, got.cell_area); errors++;
            end
            if (got.area_valid !== e.area_valid) begin
                $error("area_valid exp %0b got %0b", e.area_valid, got.area_valid); errors++;
            end
            if (got.inormal_x !== e.inormal_x) begin
                $error("inormal_x exp %0d got %0d", e.inormal_x, got.inormal_x); errors++;
            end
            if (got.inormal_y !== e.inormal_y) begin
                $error("inormal_y exp %0d got %0d", e.inormal_y, got.inormal_y); errors++;
            end
            if (got.inormal_valid !== e.inormal_valid) begin
                $error("inormal_valid exp %0b got %0b", e.inormal_valid, got.inormal_valid);
                errors++;
            end
            if (got.jnormal_x !== e.jnormal_x) begin
                $error("jnormal_x exp %0d got %0d", e.jnormal_x, got.jnormal_x); errors++;
            end
            if (got.jnormal_y !== e.jnormal_y) begin
                $error("jnormal_y exp %0d got %0d", e.jnormal_y, got.jnormal_y); errors++;
            end
            if (got.jnormal_valid !== e.jnormal_valid) begin
                $error("jnormal_valid exp %0b got %0b", e.jnormal_valid, got.jnormal_valid);
                errors++;
            end
            if (got.grid_done !== e.grid_done) begin
                $error("grid_done exp %0b got %0b", e.grid_done, got.grid_done); errors++;
            end
        endfunction
    endclass

    localparam int LATENCY = 60;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    gcam_pkg::t_in_item            i_in_data;
    logic                          o_in_stall;
    logic                          o_out_valid;
    gcam_pkg::t_out_item           o_out_data;
    logic                          i_out_stall;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic                          i_cfg_index;
    logic [gcam_pkg::CFG_W-1:0]    i_cfg_data;

    metric_board board;
    bit          idle_en;   // random gaps and stalls allowed

    grid_cell_area_and_face_normals_2d u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: worst case ~1700 nodes with input gaps and output stalls, plus drains,
    // taken many times over.
    initial begin
        #(12ns * 2_000_000);
        $display("grid_cell_area_and_face_normals_2d verification failed");
        $finish;
    end

    // Result side: random stall bursts, check every transfer at the rising edge.
    initial begin
        int burst;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) board.check_result(o_out_data);
            @(negedge i_clk);
            if (burst > 0) begin
                burst--;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 14);
            end
            i_out_stall = (burst > 0);
        end
    end

    task automatic write_reg(logic idx, logic [gcam_pkg::CFG_W-1:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Wait for the pipe to drain before touching registers.
    task automatic drain();
        while (board.owed_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    task automatic send_node(logic signed [gcam_pkg::COORD_BITS-1:0] x,
                             logic signed [gcam_pkg::COORD_BITS-1:0] y);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data.coord_x = x;
        i_in_data.coord_y = y;
        do @(posedge i_clk); while (o_in_stall);
        board.note_node(i_in_data);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // Mostly near-neighbor walks so areas and normals stay varied; some full-range noise.
    function automatic logic signed [gcam_pkg::COORD_BITS-1:0] rand_coord(int col, int row,
                                                                         bit wild);
        int base;
        if (wild) return gcam_pkg::COORD_BITS'($urandom);
        base = (col + row) * ($urandom_range(0, 1) ? 4096 : 37);
        return gcam_pkg::COORD_BITS'(base + $signed($urandom_range(0, 16383)) - 8192);
    endfunction

    task automatic run_grid(int npr, int rows, bit wild);
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < npr; c++) begin
                logic signed [gcam_pkg::COORD_BITS-1:0] x, y;
                x = rand_coord(c, r, wild);
                y = rand_coord(r, c, wild);
                send_node(x, y);
            end
    endtask

    initial begin
        int sent;
        logic signed [gcam_pkg::COORD_BITS-1:0] xmax, xmin;
        board = new();
        board.clear();
        idle_en     = 1'b1;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = gcam_pkg::CFG_NODES_PER_ROW;
        i_cfg_data  = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: smallest grid with extreme corners, zero-length edges, axis edges.
        xmax = {1'b0, {(gcam_pkg::COORD_BITS-1){1'b1}}};
        xmin = {1'b1, {(gcam_pkg::COORD_BITS-1){1'b0}}};
        write_reg(gcam_pkg::CFG_NODES_PER_ROW, 16'd2);
        write_reg(gcam_pkg::CFG_ROWS_IN_GRID, 16'd2);
        send_node(xmin, xmin); send_node(xmax, xmax);
        send_node(xmax, xmin); send_node(xmin, xmax);
        // zero-length edges everywhere
        repeat (4) send_node(24'sd100, -24'sd100);
        // axis-aligned unit square: normals of exactly +1 and -1
        send_node('0, '0); send_node(24'sd4096, '0);
        send_node('0, 24'sd4096); send_node(24'sd4096, 24'sd4096);
        send_node(24'sd4096, 24'sd4096); send_node('0, 24'sd4096);
        send_node(24'sd4096, '0); send_node('0, '0);
        // 3x3 mixed
        drain();
        write_reg(gcam_pkg::CFG_NODES_PER_ROW, 16'd3);
        write_reg(gcam_pkg::CFG_ROWS_IN_GRID, 16'd3);
        run_grid(3, 3, 1'b1);

        // Out-of-range register values get clamped by the block.
        drain();
        write_reg(gcam_pkg::CFG_NODES_PER_ROW, 16'd0);
        write_reg(gcam_pkg::CFG_ROWS_IN_GRID, 16'd0);
        run_grid(2, 2, 1'b0);
        drain();
        write_reg(gcam_pkg::CFG_NODES_PER_ROW, 16'h7ff);
        write_reg(gcam_pkg::CFG_ROWS_IN_GRID, 16'hffff);
        run_grid(1024, 1, 1'b0);  // one full row at the largest size, grid stays open
        drain();
        write_reg(gcam_pkg::CFG_NODES_PER_ROW, 16'd2);
        write_reg(gcam_pkg::CFG_ROWS_IN_GRID, 16'd2);
        run_grid(2, 1, 1'b1);     // shorter second row closes the grid with grid_done

        // Random small grids; every grid starts fresh, so every line store entry that
        // a j-edge or an area uses was written earlier in the same grid.
        sent = 0;
        while (sent < 650) begin
            int npr, rows;
            npr  = $urandom_range(2, 9);
            rows = $urandom_range(2, 6);
            if (sent > 500) idle_en = 1'b0;
            drain();
            write_reg(gcam_pkg::CFG_NODES_PER_ROW, gcam_pkg::CFG_W'(npr));
            write_reg(gcam_pkg::CFG_ROWS_IN_GRID, gcam_pkg::CFG_W'(rows));
            run_grid(npr, rows, $urandom_range(0, 4) == 0);
            sent += npr * rows;
        end

        drain();
        if (board.errors == 0) begin
            $display("grid_cell_area_and_face_normals_2d verification clean");
        end else begin
            $display("grid_cell_area_and_face_normals_2d verification failed");
        end
        $finish;
    end

endmodule
